>>> rtl/text_console_writer_unit_defines.svh
// Assertion macros for the text console RTL.
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TCW_ASSERT_IMPL(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("text console check failed");
`define TCW_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("text console check failed");
`else
`define TCW_ASSERT_IMPL(lbl, clk_s, rst_n, ante, cons)
`define TCW_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons)
`endif
`endif

>>> rtl/tcw_pkg.sv
package tcw_pkg;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_END   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SWEEP
	} state_t;

	// Request to walk the whole cell memory: scroll up one row or fill.
	typedef struct packed {
		logic       go;
		logic       scroll;
		logic [7:0] attr;
	} sweep_req_t;

	localparam logic [7:0] ESC_BYTE   = 8'hFF;
	localparam logic [7:0] NL_BYTE    = 8'h0A;
	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] RESET_ATTR = 8'h07;

endpackage

>>> rtl/tcw_cell_ram.sv
module tcw_cell_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/tcw_sweep.sv
module tcw_sweep #(
	parameter int CELLS   = 2000,
	parameter int COLUMNS = 80,
	parameter int AW      = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tcw_pkg::sweep_req_t req,
	input  logic [15:0]        rdata,
	output logic [AW-1:0]      raddr,
	output logic               we,
	output logic [AW-1:0]      waddr,
	output logic [15:0]        wdata,
	output logic               done
);

	localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_LIMIT = AW'(CELLS - COLUMNS);

	logic          active_q;
	logic          scroll_q;
	logic [7:0]    attr_q;
	logic [AW-1:0] cnt_q;
	logic          v_s1;
	logic          copy_s1;
	logic          last_s1;
	logic [AW-1:0] addr_s1;

	// Reset starts a fill pass with the default attribute.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			scroll_q <= 1'b0;
			attr_q   <= tcw_pkg::RESET_ATTR;
			cnt_q    <= '0;
			v_s1     <= 1'b0;
		end else begin
			v_s1 <= active_q;
			if (req.go) begin
				active_q <= 1'b1;
				scroll_q <= req.scroll;
				attr_q   <= req.attr;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + AW'(1);
				if (cnt_q == LAST_CELL) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	// The source cell one row down is read while the write waits one stage for its data.
	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q;
		copy_s1 <= scroll_q && (cnt_q < COPY_LIMIT);
		last_s1 <= cnt_q == LAST_CELL;
	end

	assign raddr = cnt_q + AW'(COLUMNS);
	assign we    = v_s1;
	assign waddr = addr_s1;
	assign wdata = copy_s1 ? rdata : {attr_q, tcw_pkg::BLANK_CHAR};
	assign done  = v_s1 && last_s1;

endmodule

>>> rtl/text_console_writer_unit.sv
// Character-cell text console of ROWS x COLUMNS cells, 16 bits each (attribute:char).
// A request is taken when start is high and busy is low; command, byte_value and
// cell_index are sampled at that edge. Each request gives one result, shown for
// exactly one cycle with done high: cursor_update, cursor_position, cell_char and
// cell_attr. The receiver cannot stall, so results are never held back.
// A put without scroll, an end of string and an escape byte give done in
// the next cycle, and busy stays low, so such requests may follow every cycle.
// A cell read waits in the READ state for the cell memory's registered read port.
// A scroll (newline or wrap on the last row) and a clear screen walk the whole cell
// memory one cell a cycle through the sweep unit: done follows the last cell write,
// and busy is high meanwhile.
// After reset the sweep unit fills all ROWS*COLUMNS cells with a blank of attribute
// 7, which holds busy high until the sweep ends and gives no result.
// Reads of cells at or beyond ROWS*COLUMNS return zero.
`include "text_console_writer_unit_defines.svh"

module text_console_writer_unit #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  command,
	input  logic [7:0]  byte_value,
	input  logic [10:0] cell_index,
	output logic        busy,
	output logic        done,
	output logic        cursor_update,
	output logic [10:0] cursor_position,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_attr
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int IW    = (AW > 11) ? AW : 11;

	tcw_pkg::state_t     state_q, state_d;
	tcw_pkg::cmd_t       cmd;
	tcw_pkg::sweep_req_t req;

	logic          accept;
	logic          go_read;
	logic          sweeping;
	logic          sweep_done;
	logic          adv;

	logic [7:0]    attr_q, attr_d;
	logic          esc_q, esc_d;
	logic [RW-1:0] row_q, row_d;
	logic [CW-1:0] col_q, col_d;
	logic [AW-1:0] pos_q, pos_d;
	logic [AW-1:0] base_q, base_d;
	logic          pend_q;
	logic          done_q;
	logic          upd_d, upd_q;
	logic          rd_ok_q;
	logic [7:0]    cch_q, cat_q;

	logic [IW-1:0] idx_w;
	logic [IW-1:0] pos_w;
	logic          in_range;

	logic          top_we;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [15:0]   ram_wdata, ram_rdata;
	logic [AW-1:0] sw_raddr, sw_waddr;
	logic          sw_we;
	logic [15:0]   sw_wdata;

	assign cmd      = tcw_pkg::cmd_t'(command);
	assign busy     = state_q != tcw_pkg::ST_IDLE;
	assign accept   = start && !busy;
	assign sweeping = state_q == tcw_pkg::ST_SWEEP;
	assign idx_w    = IW'(cell_index);
	assign in_range = idx_w < IW'(CELLS);

	// Cursor, attribute, cell write, read and sweep requests for an accepted request.
	always_comb begin
		attr_d  = attr_q;
		esc_d   = esc_q;
		row_d   = row_q;
		col_d   = col_q;
		pos_d   = pos_q;
		base_d  = base_q;
		top_we  = 1'b0;
		upd_d   = 1'b0;
		go_read = 1'b0;
		adv     = 1'b0;
		req     = '{go: 1'b0, scroll: 1'b0, attr: attr_q};
		if (accept) begin
			case (cmd)
				tcw_pkg::CMD_PUT: begin
					if (esc_q) begin
						attr_d = byte_value;
						esc_d  = 1'b0;
					end else if (byte_value == tcw_pkg::ESC_BYTE) begin
						esc_d = 1'b1;
					end else begin
						adv    = (byte_value == tcw_pkg::NL_BYTE) || (col_q == CW'(COLUMNS - 1));
						top_we = byte_value != tcw_pkg::NL_BYTE;
						if (adv) begin
							col_d = '0;
							if (row_q == RW'(ROWS - 1)) begin
								// The last row stays the cursor row; its base is unchanged.
								pos_d      = base_q;
								req.go     = 1'b1;
								req.scroll = 1'b1;
								upd_d      = 1'b1;
							end else begin
								row_d  = row_q + RW'(1);
								base_d = base_q + AW'(COLUMNS);
								pos_d  = base_q + AW'(COLUMNS);
							end
						end else begin
							col_d = col_q + CW'(1);
							pos_d = pos_q + AW'(1);
						end
					end
				end
				tcw_pkg::CMD_END: begin
					esc_d = 1'b0;
					upd_d = 1'b1;
				end
				tcw_pkg::CMD_CLEAR: begin
					attr_d   = byte_value;
					esc_d    = 1'b0;
					row_d    = '0;
					col_d    = '0;
					pos_d    = '0;
					base_d   = '0;
					upd_d    = 1'b1;
					req.go   = 1'b1;
					req.attr = byte_value;
				end
				tcw_pkg::CMD_READ: begin
					go_read = 1'b1;
				end
				default: begin
					go_read = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tcw_pkg::ST_IDLE: begin
				if (go_read) begin
					state_d = tcw_pkg::ST_READ;
				end else if (req.go) begin
					state_d = tcw_pkg::ST_SWEEP;
				end
			end
			tcw_pkg::ST_READ: begin
				state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_SWEEP: begin
				if (sweep_done) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_SWEEP;
			attr_q  <= tcw_pkg::RESET_ATTR;
			esc_q   <= 1'b0;
			row_q   <= '0;
			col_q   <= '0;
			pos_q   <= '0;
			base_q  <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			attr_q  <= attr_d;
			esc_q   <= esc_d;
			row_q   <= row_d;
			col_q   <= col_d;
			pos_q   <= pos_d;
			base_q  <= base_d;
			if (accept) begin
				pend_q <= req.go;
			end
			done_q <= (accept && !go_read && !req.go) ||
				(state_q == tcw_pkg::ST_READ) ||
				(sweeping && sweep_done && pend_q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			upd_q   <= upd_d;
			rd_ok_q <= in_range;
			cch_q   <= '0;
			cat_q   <= '0;
		end else if (state_q == tcw_pkg::ST_READ && rd_ok_q) begin
			cch_q <= ram_rdata[7:0];
			cat_q <= ram_rdata[15:8];
		end
	end

	assign ram_we    = sweeping ? sw_we : top_we;
	assign ram_waddr = sweeping ? sw_waddr : pos_q;
	assign ram_wdata = sweeping ? sw_wdata : {attr_q, byte_value};
	assign ram_raddr = sweeping ? sw_raddr : idx_w[AW-1:0];

	tcw_cell_ram #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tcw_sweep #(
		.CELLS  (CELLS),
		.COLUMNS(COLUMNS),
		.AW     (AW)
	) u_sweep (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rdata (ram_rdata),
		.raddr (sw_raddr),
		.we    (sw_we),
		.waddr (sw_waddr),
		.wdata (sw_wdata),
		.done  (sweep_done)
	);

	assign pos_w           = IW'(pos_q);
	assign done            = done_q;
	assign cursor_update   = upd_q;
	assign cursor_position = pos_w[10:0];
	assign cell_char       = cch_q;
	assign cell_attr       = cat_q;

	`TCW_ASSERT_NEXT(a_accept_answered, clk, arst_n, accept, done || busy)
	`TCW_ASSERT_IMPL(a_done_when_idle, clk, arst_n, done, !busy)
	`TCW_ASSERT_IMPL(a_col_range, clk, arst_n, 1'b1, ({1'b0, col_q} < (CW+1)'(COLUMNS)))
	`TCW_ASSERT_IMPL(a_row_range, clk, arst_n, 1'b1, ({1'b0, row_q} < (RW+1)'(ROWS)))
	`TCW_ASSERT_IMPL(a_pos_tracks, clk, arst_n, 1'b1, pos_q == base_q + AW'(col_q))

endmodule

>>> tb/sv/text_console_writer_unit_test.sv
module text_console_writer_unit_test;
	import tcw_pkg::*;

	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = COLUMNS * ROWS;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic        cursor_update;
		logic [10:0] cursor_position;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
	} console_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic [1:0]  command;
	logic [7:0]  byte_value;
	logic [10:0] cell_index;
	logic        busy;
	logic        done;
	logic        cursor_update;
	logic [10:0] cursor_position;
	logic [7:0]  cell_char;
	logic [7:0]  cell_attr;

	// Shadow copy of the console: cells are {attribute, character}.
	logic [15:0] shadow_cells [CELLS];
	logic [7:0]  shadow_attr;
	int unsigned shadow_row;
	int unsigned shadow_col;
	bit          shadow_escape;

	console_result_t expected_results [$];
	int mismatch_count;
	int requests_sent;
	int results_checked;
	int sweeps_predicted;
	int reads_sent;
	int cycle_count;
	int sender_idle_pct;

	text_console_writer_unit #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.command(command),
		.byte_value(byte_value),
		.cell_index(cell_index),
		.busy(busy),
		.done(done),
		.cursor_update(cursor_update),
		.cursor_position(cursor_position),
		.cell_char(cell_char),
		.cell_attr(cell_attr)
	);

	always #1 clk = ~clk;

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255, 0));
	endfunction

	function automatic logic [7:0] rand_printable();
		return 8'($urandom_range(126, 32));
	endfunction

	function automatic logic [10:0] rand_index();
		return 11'($urandom_range(2047, 0));
	endfunction

	function automatic void blank_screen(logic [7:0] attr);
		for (int i = 0; i < CELLS; i++)
			shadow_cells[i] = {attr, BLANK_CHAR};
	endfunction

	// Returns 1 when moving down pushed the screen up by one row.
	function automatic bit move_to_next_row();
		shadow_col = 0;
		shadow_row++;
		if (shadow_row >= ROWS) begin
			shadow_row = ROWS - 1;
			for (int i = 0; i < CELLS - COLUMNS; i++)
				shadow_cells[i] = shadow_cells[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				shadow_cells[i] = {shadow_attr, BLANK_CHAR};
			sweeps_predicted++;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic int shadow_cursor();
		return shadow_row * COLUMNS + shadow_col;
	endfunction

	function automatic console_result_t advance_console(cmd_t op, logic [7:0] value,
			logic [10:0] index);
		console_result_t res;
		int pos;
		res = '0;
		case (op)
			CMD_PUT: begin
				if (shadow_escape) begin
					shadow_attr = value;
					shadow_escape = 1'b0;
				end else if (value == ESC_BYTE) begin
					shadow_escape = 1'b1;
				end else if (value == NL_BYTE) begin
					res.cursor_update = move_to_next_row();
				end else begin
					shadow_cells[shadow_cursor()] = {shadow_attr, value};
					shadow_col++;
					if (shadow_col >= COLUMNS)
						res.cursor_update = move_to_next_row();
				end
			end
			CMD_END: begin
				shadow_escape = 1'b0;
				res.cursor_update = 1'b1;
			end
			CMD_CLEAR: begin
				shadow_attr = value;
				blank_screen(value);
				shadow_row = 0;
				shadow_col = 0;
				shadow_escape = 1'b0;
				res.cursor_update = 1'b1;
				sweeps_predicted++;
			end
			default: begin
				reads_sent++;
				if (index < CELLS)
					{res.cell_attr, res.cell_char} = shadow_cells[index];
			end
		endcase
		pos = shadow_cursor();
		res.cursor_position = pos[10:0];
		return res;
	endfunction

	task automatic issue_request(cmd_t op, logic [7:0] value, logic [10:0] index);
		@(negedge clk);
		while ($urandom_range(99, 0) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		command <= op;
		byte_value <= value;
		cell_index <= index;
		// busy is read before the edge updates it, so this is the value the block saw.
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_results.push_back(advance_console(op, value, index));
		requests_sent++;
	endtask

	task automatic note_mismatch(string what, logic [15:0] wanted, logic [15:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch on %s: expected %h, got %h", what, wanted, got);
	endtask

	always @(posedge clk) begin : result_checker
		console_result_t want;
		if (arst_n && done) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				note_mismatch("unrequested result position", 16'h0, 16'(cursor_position));
			end else begin
				want = expected_results.pop_front();
				if (cursor_update !== want.cursor_update)
					note_mismatch("cursor_update", 16'(want.cursor_update),
						16'(cursor_update));
				if (cursor_position !== want.cursor_position)
					note_mismatch("cursor_position", 16'(want.cursor_position),
						16'(cursor_position));
				if (cell_char !== want.cell_char)
					note_mismatch("cell_char", 16'(want.cell_char), 16'(cell_char));
				if (cell_attr !== want.cell_attr)
					note_mismatch("cell_attr", 16'(want.cell_attr), 16'(cell_attr));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic test_reset_screen();
		issue_request(CMD_READ, 8'h00, 11'd0);
		issue_request(CMD_READ, 8'hFF, 11'd1999);
		issue_request(CMD_READ, 8'h5A, 11'd2047);
	endtask

	task automatic test_escape_sequences();
		issue_request(CMD_PUT, ESC_BYTE, 11'h7FF);
		// The newline byte after an escape is an attribute, not a line break.
		issue_request(CMD_PUT, NL_BYTE, 11'd0);
		issue_request(CMD_PUT, 8'h00, 11'd0);
		issue_request(CMD_PUT, ESC_BYTE, 11'd0);
		issue_request(CMD_END, 8'hA5, 11'd1234);
		issue_request(CMD_PUT, ESC_BYTE, 11'd0);
		issue_request(CMD_READ, 8'h00, 11'd0);
		issue_request(CMD_PUT, ESC_BYTE, 11'd0);
		issue_request(CMD_PUT, 8'hFE, 11'd0);
		issue_request(CMD_READ, 8'h00, 11'd1);
	endtask

	task automatic test_clear_screen();
		issue_request(CMD_PUT, ESC_BYTE, 11'd0);
		issue_request(CMD_CLEAR, 8'h0E, 11'd555);
		issue_request(CMD_PUT, 8'h80, 11'd0);
		issue_request(CMD_READ, 8'h00, 11'd0);
		issue_request(CMD_READ, 8'h00, 11'd1999);
	endtask

	task automatic test_scroll_up();
		for (int i = 0; i < ROWS - 1; i++)
			issue_request(CMD_PUT, NL_BYTE, 11'd0);
		issue_request(CMD_PUT, 8'h5A, 11'd0);
		issue_request(CMD_PUT, NL_BYTE, 11'd0);
		issue_request(CMD_READ, 8'h00, 11'(CELLS - 2 * COLUMNS));
	endtask

	// Strings of printable text with newlines and attribute escapes, each usually
	// closed by an end of string or a clear screen, with cell reads between them.
	task automatic run_random_traffic(int idle_pct, int item_goal);
		int goal;
		int length;
		int pick;
		int spot;
		bit long_line;
		goal = requests_sent + item_goal;
		sender_idle_pct = idle_pct;
		while (requests_sent < goal) begin
			long_line = ($urandom_range(99, 0) < 15);
			length = long_line ? $urandom_range(120, 40) : $urandom_range(30, 1);
			for (int i = 0; i < length; i++) begin
				pick = $urandom_range(99, 0);
				if (pick < 4) begin
					issue_request(CMD_PUT, rand_byte(), rand_index());
				end else if (pick < 10) begin
					issue_request(CMD_PUT, ESC_BYTE, rand_index());
					issue_request(CMD_PUT, rand_byte(), rand_index());
				end else if (pick < 20 && !long_line) begin
					issue_request(CMD_PUT, NL_BYTE, rand_index());
				end else begin
					issue_request(CMD_PUT, rand_printable(), rand_index());
				end
			end
			if ($urandom_range(9, 0) == 0)
				issue_request(CMD_PUT, ESC_BYTE, rand_index());
			if ($urandom_range(24, 0) == 0)
				issue_request(CMD_CLEAR, rand_byte(), rand_index());
			else if ($urandom_range(9, 0) != 0)
				issue_request(CMD_END, rand_byte(), rand_index());
			for (int i = $urandom_range(3, 0); i > 0; i--) begin
				pick = $urandom_range(99, 0);
				if (pick < 45)
					spot = shadow_cursor() > 0 ? shadow_cursor() - 1 : 0;
				else if (pick < 75)
					spot = $urandom_range(CELLS - 1, 0);
				else if (pick < 85)
					spot = $urandom_range(CELLS - 1, CELLS - COLUMNS);
				else if (pick < 92)
					spot = $urandom_range(2047, CELLS);
				else
					spot = $urandom_range(2047, 0);
				issue_request(CMD_READ, rand_byte(), spot[10:0]);
			end
		end
	endtask

	task automatic finish_run();
		@(negedge clk);
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		// A scroll or a clear is the longest operation; any stray result shows up well within this.
		repeat (2 * CELLS + 10)
			@(posedge clk);
		$display("%0d requests sent, %0d of them reads, %0d screen scrolls and clears",
			requests_sent, reads_sent, sweeps_predicted);
		$display("%0d results checked, %0d mismatches", results_checked, mismatch_count);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_PUT;
		byte_value = 8'h00;
		cell_index = 11'd0;
		blank_screen(RESET_ATTR);
		shadow_attr = RESET_ATTR;
		shadow_row = 0;
		shadow_col = 0;
		shadow_escape = 1'b0;
		repeat (8)
			@(negedge clk);
		arst_n <= 1'b1;
		sender_idle_pct = 16;
		test_reset_screen();
		test_escape_sequences();
		test_clear_screen();
		test_scroll_up();
		run_random_traffic(16, 500);
		run_random_traffic(57, 500);
		run_random_traffic(0, 510);
		finish_run();
	end

endmodule
